// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the box blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: hw/rtl/bbea_pkg.sv
// Types, constants and helpers shared by the box blur modules.
package bbea_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COL_W + 1;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int ROW_W     = FRAME_HEIGHT_W;
  localparam int LEAD_W    = WIDTH_W;
  localparam int CHAN_W    = 8;
  localparam int PIXEL_W   = 3 * CHAN_W;
  localparam int SLOTS     = 3;
  localparam int SLOT_W    = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // sum of up to nine channel values
  localparam int SUM_W   = CHAN_W + 4;
  localparam int NUM_W   = SUM_W + 1;
  localparam int COUNT_W = 4;

  // floor(x / 2n) == (x * ceil(2^K / 2n)) >> K for every x below 2^NUM_W
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = RECIP_SHIFT;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_N1 = RECIP_W'((2**RECIP_SHIFT + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_N2 = RECIP_W'((2**RECIP_SHIFT + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_N3 = RECIP_W'((2**RECIP_SHIFT + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_N4 = RECIP_W'((2**RECIP_SHIFT + 7) / 8);
  localparam logic [RECIP_W-1:0] RECIP_N6 = RECIP_W'((2**RECIP_SHIFT + 11) / 12);
  localparam logic [RECIP_W-1:0] RECIP_N9 = RECIP_W'((2**RECIP_SHIFT + 17) / 18);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic               store;
    logic               emit;
    logic               emit_first;
    logic [SLOT_W-1:0]  slot;
    logic [COL_W-1:0]   col;
    logic [PIXEL_W-1:0] pixel;
  } job_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    unique case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    unique case (s)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd2:    m = RECIP_N2;
      4'd3:    m = RECIP_N3;
      4'd4:    m = RECIP_N4;
      4'd6:    m = RECIP_N6;
      4'd9:    m = RECIP_N9;
      default: m = RECIP_N1;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/bbea_pix_if.sv
// Input channel: pixel or drain command beats.
interface bbea_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bbea_pkg::CHAN_W-1:0] in_red;
  logic [bbea_pkg::CHAN_W-1:0] in_green;
  logic [bbea_pkg::CHAN_W-1:0] in_blue;

  modport source (output valid, output cmd, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink   (input valid, input cmd, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

// File: hw/rtl/bbea_avg_if.sv
// Output channel: blurred pixel beats.
interface bbea_avg_if;
  logic                        valid;
  logic                        ready;
  logic [bbea_pkg::CHAN_W-1:0] out_red;
  logic [bbea_pkg::CHAN_W-1:0] out_green;
  logic [bbea_pkg::CHAN_W-1:0] out_blue;
  logic                        frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

// File: hw/rtl/bbea_cfg_if.sv
// Configuration write channel.
interface bbea_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bbea_pkg::CFG_INDEX_W-1:0] index;
  logic [bbea_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/box_blur_3x3_edge_average_top.sv
// Top level of the 3x3 box blur: configuration registers and the front, queue and back.
// Takes RGB pixels of a frame in raster order and returns each pixel as the rounded-half-up
// mean of its 3x3 neighborhood clipped to the frame (9, 6 or 4 neighbors, fewer on frames one
// pixel wide or tall). Outputs lag inputs by frame_width+1 pixels across frame borders; after
// the last pixel of a frame, drain beats (cmd = 1) push out the tail one pixel each, and
// frame_end marks the last pixel of the frame. A pixel that only fills the line stores takes
// one store step in the back end; an item that yields an output adds the three-column read
// sweep over the three line-store banks, kept apart from the single write port, and the
// reciprocal scaling step (drain beats store nothing). A 4-entry job queue lets the input
// side run ahead while a result waits on the output. The line stores need no clearing after
// reset. Write frame_width (index 0, 1..2048, zero taken as 1, larger saturates) and
// frame_height (index 1, zero taken as 1) only while the block is idle.
module box_blur_3x3_edge_average_top (
  input  logic       clk,
  input  logic       rst,
  bbea_pix_if.sink   pixels,
  bbea_avg_if.source averages,
  bbea_cfg_if.sink   cfg
);

  logic [bbea_pkg::WIDTH_W-1:0]       frame_width;
  logic [bbea_pkg::ROW_W-1:0]         frame_height;
  logic [bbea_pkg::FRAME_WIDTH_W-1:0] raw_width;

  logic           push_valid;
  logic           push_ready;
  bbea_pkg::job_t push_data;
  logic           job_valid;
  logic           job_ready;
  bbea_pkg::job_t job;

  assign cfg.ready = 1'b1;
  assign raw_width = cfg.data[bbea_pkg::FRAME_WIDTH_W-1:0];

  // hold the effective sizes: zero maps to one, width saturates at the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbea_pkg::WIDTH_W'(640);
      frame_height <= bbea_pkg::ROW_W'(480);
    end else if (cfg.valid) begin
      unique case (bbea_pkg::cfg_reg_t'(cfg.index))
        bbea_pkg::REG_FRAME_WIDTH: begin
          if (raw_width == '0) begin
            frame_width <= bbea_pkg::WIDTH_W'(1);
          end else if (raw_width > bbea_pkg::MAX_WIDTH) begin
            frame_width <= bbea_pkg::WIDTH_W'(bbea_pkg::MAX_WIDTH);
          end else begin
            frame_width <= bbea_pkg::WIDTH_W'(raw_width);
          end
        end
        bbea_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= (cfg.data[bbea_pkg::FRAME_HEIGHT_W-1:0] == '0) ? bbea_pkg::ROW_W'(1)
                        : cfg.data[bbea_pkg::FRAME_HEIGHT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  bbea_front u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pix          (pixels),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  bbea_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job)
  );

  bbea_back u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .avg          (averages)
  );

endmodule

// File: hw/rtl/bbea_front.sv
// Front end: accepts beats, tracks the input position and lead, issues jobs.
module bbea_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bbea_pkg::WIDTH_W-1:0]   frame_width,
  input  logic [bbea_pkg::ROW_W-1:0]     frame_height,
  bbea_pix_if.sink                       pix,
  output logic                           push_valid,
  input  logic                           push_ready,
  output bbea_pkg::job_t                 push_data
);

  logic [bbea_pkg::COL_W-1:0]  in_column;
  logic [bbea_pkg::ROW_W-1:0]  in_row;
  logic [bbea_pkg::SLOT_W-1:0] in_slot;
  logic [bbea_pkg::LEAD_W-1:0] lead;

  logic is_pixel;
  logic send;
  logic drain_emit;
  logic accept;
  logic col_wrap;
  logic row_wrap;

  assign is_pixel   = (pix.cmd == bbea_pkg::CMD_PIXEL);
  // lead >= width + 1
  assign send       = (lead > frame_width);
  assign drain_emit = (in_row == '0) && (in_column == '0) && (lead != '0);
  assign accept     = pix.valid && push_ready;

  assign col_wrap = ({1'b0, in_column} + bbea_pkg::WIDTH_W'(1)) >= frame_width;
  assign row_wrap = ({1'b0, in_row} + (bbea_pkg::ROW_W + 1)'(1)) >= {1'b0, frame_height};

  assign pix.ready  = push_ready;
  // drop drain beats that have nothing to flush
  assign push_valid = pix.valid && (is_pixel || drain_emit);

  always_comb begin
    push_data.store      = is_pixel;
    push_data.emit       = is_pixel ? send : 1'b1;
    push_data.emit_first = (in_column == '0);
    push_data.slot       = in_slot;
    push_data.col        = in_column;
    push_data.pixel      = {pix.in_red, pix.in_green, pix.in_blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      in_slot   <= '0;
      lead      <= '0;
    end else if (accept) begin
      if (is_pixel) begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= row_wrap ? '0 : in_row + bbea_pkg::ROW_W'(1);
          in_slot   <= bbea_pkg::slot_next(in_slot);
        end else begin
          in_column <= in_column + bbea_pkg::COL_W'(1);
        end
        if (!send) begin
          lead <= lead + bbea_pkg::LEAD_W'(1);
        end
      end else if (drain_emit) begin
        lead <= lead - bbea_pkg::LEAD_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/bbea_queue.sv
// Short job queue between the front and back ends.
`include "assert_macros.svh"

module bbea_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bbea_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bbea_pkg::job_t pop_data
);

  bbea_pkg::job_t entries [bbea_pkg::QUEUE_DEPTH];

  logic [bbea_pkg::QPTR_W-1:0] wr_ptr;
  logic [bbea_pkg::QPTR_W-1:0] rd_ptr;
  logic [bbea_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != bbea_pkg::QCNT_W'(bbea_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bbea_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bbea_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bbea_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bbea_pkg::QCNT_W'(1);
      end
    end
  end

  `ASSERT_AT(a_queue_bound, clk, rst, count <= bbea_pkg::QCNT_W'(bbea_pkg::QUEUE_DEPTH), "job queue count beyond depth")
  `ASSERT_AT(a_queue_grow, clk, rst, push && !pop |=> count == $past(count) + 1'b1, "job queue lost a push")

endmodule

// File: hw/rtl/bbea_back.sv
// Back end: line store banks, 3x3 window sum, rounded mean and output register.
`include "assert_macros.svh"

module bbea_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bbea_pkg::WIDTH_W-1:0] frame_width,
  input  logic [bbea_pkg::ROW_W-1:0]   frame_height,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  bbea_pkg::job_t               job,
  bbea_avg_if.source                   avg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE_PRE,
    ST_READ,
    ST_STORE_POST,
    ST_SCALE
  } state_t;

  state_t         state;
  bbea_pkg::job_t cur;

  logic [bbea_pkg::COL_W-1:0]  out_column;
  logic [bbea_pkg::ROW_W-1:0]  out_row;
  logic [bbea_pkg::SLOT_W-1:0] out_slot;

  logic [bbea_pkg::COL_W-1:0]  col_base;
  logic                        has_up;
  logic                        has_down;
  logic                        has_left;
  logic                        has_right;
  logic [bbea_pkg::SLOT_W-1:0] up_slot;
  logic [bbea_pkg::SLOT_W-1:0] mid_slot;
  logic [bbea_pkg::SLOT_W-1:0] down_slot;
  logic [1:0]                  rd_step;
  logic [bbea_pkg::SUM_W-1:0]  sum [3];

  logic                        avg_valid;
  logic [bbea_pkg::CHAN_W-1:0] avg_chan [3];
  logic                        avg_last;

  // window position of the next output, clamped to the frame
  logic [bbea_pkg::COL_W-1:0] c_cl;
  logic [bbea_pkg::ROW_W-1:0] r_cl;

  logic                         mem_we;
  logic                         rd_en;
  logic [bbea_pkg::COL_W-1:0]   rd_addr;
  logic [bbea_pkg::PIXEL_W-1:0] rd_data [bbea_pkg::SLOTS];

  logic                         col_ok;
  logic [bbea_pkg::PIXEL_W-1:0] up_px;
  logic [bbea_pkg::PIXEL_W-1:0] mid_px;
  logic [bbea_pkg::PIXEL_W-1:0] down_px;
  logic [bbea_pkg::SUM_W-1:0]   sum_next [3];

  logic [1:0]                    n_rows;
  logic [1:0]                    n_cols;
  logic [bbea_pkg::COUNT_W-1:0]  n_count;
  logic [bbea_pkg::RECIP_W-1:0]  recip_m;
  logic [bbea_pkg::NUM_W-1:0]    num [3];
  logic [bbea_pkg::PROD_W-1:0]   prod [3];

  logic res_load;
  logic col_wrap;
  logic row_wrap;

  assign job_ready = (state == ST_IDLE);

  assign c_cl = ({1'b0, out_column} < frame_width) ? out_column
              : bbea_pkg::COL_W'(frame_width - bbea_pkg::WIDTH_W'(1));
  assign r_cl = (out_row < frame_height) ? out_row : frame_height - bbea_pkg::ROW_W'(1);

  assign mem_we  = (state == ST_STORE_PRE) || (state == ST_STORE_POST);
  assign rd_en   = (state == ST_READ) && (rd_step != 2'd3);
  // sweep columns c-1, c, c+1; out-of-frame columns are masked on return
  assign rd_addr = col_base + bbea_pkg::COL_W'(rd_step) - bbea_pkg::COL_W'(1);

  for (genvar b = 0; b < bbea_pkg::SLOTS; b++) begin : g_bank
    logic [bbea_pkg::PIXEL_W-1:0] mem [bbea_pkg::MAX_WIDTH];
    logic [bbea_pkg::PIXEL_W-1:0] q;

    always_ff @(posedge clk) begin
      if (mem_we && (cur.slot == bbea_pkg::SLOT_W'(b))) begin
        mem[cur.col] <= cur.pixel;
      end
      if (rd_en) begin
        q <= mem[rd_addr];
      end
    end

    assign rd_data[b] = q;
  end

  always_comb begin
    unique case (rd_step)
      2'd1:    col_ok = has_left;
      2'd3:    col_ok = has_right;
      default: col_ok = 1'b1;
    endcase
    up_px   = rd_data[up_slot];
    mid_px  = rd_data[mid_slot];
    down_px = rd_data[down_slot];
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = sum[ch]
        + bbea_pkg::SUM_W'((has_up && col_ok) ? up_px[(2-ch)*bbea_pkg::CHAN_W +: bbea_pkg::CHAN_W]
                                              : '0)
        + bbea_pkg::SUM_W'(col_ok ? mid_px[(2-ch)*bbea_pkg::CHAN_W +: bbea_pkg::CHAN_W] : '0)
        + bbea_pkg::SUM_W'((has_down && col_ok)
                           ? down_px[(2-ch)*bbea_pkg::CHAN_W +: bbea_pkg::CHAN_W] : '0);
    end
  end

  // (2*sum + n) / (2n) through a reciprocal of the neighbor count
  always_comb begin
    n_rows  = 2'd1 + {1'b0, has_up} + {1'b0, has_down};
    n_cols  = 2'd1 + {1'b0, has_left} + {1'b0, has_right};
    n_count = {2'b00, n_rows} * {2'b00, n_cols};
    recip_m = bbea_pkg::recip(n_count);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sum[ch], 1'b0} + bbea_pkg::NUM_W'(n_count);
      prod[ch] = bbea_pkg::PROD_W'(num[ch]) * bbea_pkg::PROD_W'(recip_m);
    end
  end

  assign res_load = (state == ST_SCALE) && (!avg_valid || avg.ready);
  assign col_wrap = ({1'b0, out_column} + bbea_pkg::WIDTH_W'(1)) >= frame_width;
  assign row_wrap = ({1'b0, out_row} + (bbea_pkg::ROW_W + 1)'(1)) >= {1'b0, frame_height};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_column <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      rd_step    <= '0;
      avg_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        avg_valid <= 1'b1;
      end else if (avg.ready) begin
        avg_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur       <= job;
            col_base  <= c_cl;
            has_up    <= (r_cl != '0);
            has_down  <= (r_cl != frame_height - bbea_pkg::ROW_W'(1));
            has_left  <= (c_cl != '0);
            has_right <= ({1'b0, c_cl} != frame_width - bbea_pkg::WIDTH_W'(1));
            up_slot   <= bbea_pkg::slot_prev(out_slot);
            mid_slot  <= out_slot;
            down_slot <= bbea_pkg::slot_next(out_slot);
            rd_step   <= '0;
            for (int ch = 0; ch < 3; ch++) begin
              sum[ch] <= '0;
            end
            // at a row start the window must read the slot before it is overwritten
            state <= (job.store && !(job.emit && job.emit_first)) ? ST_STORE_PRE : ST_READ;
          end
        end
        ST_STORE_PRE: begin
          state <= cur.emit ? ST_READ : ST_IDLE;
        end
        ST_READ: begin
          if (rd_step != 2'd0) begin
            for (int ch = 0; ch < 3; ch++) begin
              sum[ch] <= sum_next[ch];
            end
          end
          if (rd_step == 2'd3) begin
            rd_step <= '0;
            state   <= (cur.store && cur.emit_first) ? ST_STORE_POST : ST_SCALE;
          end else begin
            rd_step <= rd_step + 2'd1;
          end
        end
        ST_STORE_POST: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          if (res_load) begin
            for (int ch = 0; ch < 3; ch++) begin
              avg_chan[ch] <= prod[ch][bbea_pkg::RECIP_SHIFT +: bbea_pkg::CHAN_W];
            end
            avg_last <= !has_down && !has_right;
            if (col_wrap) begin
              out_column <= '0;
              out_row    <= row_wrap ? '0 : out_row + bbea_pkg::ROW_W'(1);
              out_slot   <= bbea_pkg::slot_next(out_slot);
            end else begin
              out_column <= out_column + bbea_pkg::COL_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign avg.valid     = avg_valid;
  assign avg.out_red   = avg_chan[0];
  assign avg.out_green = avg_chan[1];
  assign avg.out_blue  = avg_chan[2];
  assign avg.frame_end = avg_last;

  `ASSERT_NEVER(a_rw_overlap, clk, rst, mem_we && rd_en, "line store written during window read")
  `ASSERT_AT(a_load_shows, clk, rst, res_load |=> avg.valid, "loaded result not presented")

endmodule
